FILE: hdl/line_edit_and_field_tokenizer_defines.svh
// Assertion macros for the bound checker lef_chk.
`ifndef LINE_EDIT_AND_FIELD_TOKENIZER_DEFINES_SVH
`define LINE_EDIT_AND_FIELD_TOKENIZER_DEFINES_SVH

// Clocked assertion, switched off while reset is low.
`define LEF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define LEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/lef_pkg.sv
`default_nettype none
package lef_pkg;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Character classes
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_DELIM = 2'd0;
  localparam cls_t CLS_ALPHA = 2'd1;
  localparam cls_t CLS_NUM   = 2'd2;

  // Result beat layout
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_TUSER_W  = 2;
  localparam int TUSER_NUM    = 0;
  localparam int TUSER_EMPTY  = 1;
  localparam int IDX_W        = 3;
  localparam int START_W      = 6;
  localparam int LEN_W        = 7;
  localparam int VAL_W        = 32;

  function automatic cls_t char_class(input logic [7:0] c);
    cls_t cls;
    cls = CLS_DELIM;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      cls = CLS_NUM;
    end else if ((c >= CH_BANG && c <= CH_SLASH) || (c >= CH_COLON && c <= CH_TILDE)) begin
      cls = CLS_ALPHA;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lef_ram.sv
`default_nettype none
module lef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/line_edit_and_field_tokenizer.sv
`default_nettype none
// Serial command line editor and field tokenizer.
// Input stream: one received character per beat on in_tdata. Printable
// characters are stored, backspace/delete drop the last stored one, other
// codes are ignored. While idle, in_tready is high and beats are taken.
// A carriage return, or a character that fills the LINE_CHARS store, ends
// the line. in_tready then drops while a sequencer walks the store through
// its registered read port: each character walked takes a read step and an
// evaluate step, each field followed by another adds an emit step (then the
// next field's first character is evaluated again), the final beat has its
// own emit step, held by a stalled receiver. A field past FIELD_LIMIT
// ends the walk early. Each beat shows on out_tvalid the cycle after its
// emit step, and in_tready returns in that same cycle after the final one.
// The accumulate step (value * 10 + digit) is one shift-add unit reused for
// every character.
// Output stream: one beat per field (at most FIELD_LIMIT), tlast on the
// final beat of the line; a line with no fields gives a single beat with
// the empty flag set. A finished beat waits in the output register while
// the scan goes on to the next field; a stalled receiver holds the scan.
// Reset clears the character count, the sequencer and the output valid;
// the store contents are not cleared.
module line_edit_and_field_tokenizer
  import lef_pkg::*;
#(
  parameter int LINE_CHARS  = 64,
  parameter int FIELD_LIMIT = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] rx_char
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] field_index, [8:3] field_start, [15:9] field_length,
  // [47:16] field_value
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // [0] field_numeric, [1] line_empty
  output logic                        out_tlast   // last_field
);

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int AW = $clog2(LINE_CHARS);
  localparam int FW = $clog2(FIELD_LIMIT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [FW-1:0]    fld_r, fld_nxt;
  logic             in_fld_r, in_fld_nxt;
  logic             cur_v_r, cur_v_nxt;
  logic             last_r, last_nxt;
  logic [AW-1:0]    start_r, start_nxt;
  logic [CW-1:0]    len_r, len_nxt;
  logic             num_r, num_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;

  logic                   ovld_r, ovld_nxt;
  logic [OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic [OUT_TUSER_W-1:0] ouser_r, ouser_nxt;
  logic                   olast_r, olast_nxt;

  logic             in_acc;
  logic             we;
  logic             re;
  logic [7:0]       rd_data;
  cls_t             rd_cls;
  logic [CW-1:0]    pos_inc;
  logic [VAL_W-1:0] acc_base;
  logic [VAL_W-1:0] acc_out;
  logic             oreg_free;

  logic [FW+IDX_W-1:0]   idx_ext;
  logic [AW+START_W-1:0] start_ext;
  logic [CW+LEN_W-1:0]   len_ext;

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign re        = (st_r == ST_RD);
  assign we        = in_acc && in_tdata >= CH_SPACE && in_tdata <= CH_TILDE;

  lef_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CHARS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_tdata),
    .re    (re),
    .raddr (pos_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign rd_cls  = char_class(rd_data);
  assign pos_inc = pos_r + CW'(1);

  // Shared accumulate unit: value * 10 + (c - '0'), wrapping at 32 bits
  assign acc_base = in_fld_r ? val_r : '0;
  assign acc_out  = (acc_base << 3) + (acc_base << 1) + {24'd0, rd_data}
                    - {24'd0, CH_ZERO};

  assign oreg_free = !ovld_r || out_tready;

  // Output field widths are fixed; wider counters are masked
  assign idx_ext   = {{IDX_W{1'b0}}, fld_r - FW'(1)} ;
  assign start_ext = {{START_W{1'b0}}, start_r};
  assign len_ext   = {{LEN_W{1'b0}}, len_r};

  // Sequencer
  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    fld_nxt    = fld_r;
    in_fld_nxt = in_fld_r;
    cur_v_nxt  = cur_v_r;
    last_nxt   = last_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    num_nxt    = num_r;
    val_nxt    = val_r;
    ovld_nxt   = ovld_r && !out_tready;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt    = '0;
          fld_nxt    = '0;
          in_fld_nxt = 1'b0;
          cur_v_nxt  = 1'b0;
          last_nxt   = 1'b1;
          if (we) begin
            cnt_nxt = cnt_r + CW'(1);
            if (cnt_r + CW'(1) == CW'(LINE_CHARS)) begin
              st_nxt = ST_RD;
            end
          end else if (in_tdata == CH_BS || in_tdata == CH_DEL) begin
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end else if (in_tdata == CH_CR) begin
            st_nxt = (cnt_r == '0) ? ST_EMIT : ST_RD;
          end
        end
      end

      ST_RD: begin
        st_nxt = ST_EV;
      end

      ST_EV: begin
        if (rd_cls == CLS_DELIM) begin
          in_fld_nxt = 1'b0;
          if (in_fld_r && fld_r == FW'(FIELD_LIMIT)) begin
            last_nxt = 1'b1;
            st_nxt   = ST_EMIT;
          end else begin
            pos_nxt  = pos_inc;
            last_nxt = 1'b1;
            st_nxt   = (pos_inc == cnt_r) ? ST_EMIT : ST_RD;
          end
        end else if (!in_fld_r && cur_v_r) begin
          // Next field found: send the held one first, then revisit this char
          last_nxt = 1'b0;
          st_nxt   = ST_EMIT;
        end else begin
          if (!in_fld_r) begin
            start_nxt = pos_r[AW-1:0];
            len_nxt   = CW'(1);
            num_nxt   = (rd_cls == CLS_NUM);
            fld_nxt   = fld_r + FW'(1);
            cur_v_nxt = 1'b1;
          end else begin
            len_nxt = len_r + CW'(1);
          end
          in_fld_nxt = 1'b1;
          val_nxt    = acc_out;
          pos_nxt    = pos_inc;
          last_nxt   = 1'b1;
          st_nxt     = (pos_inc == cnt_r) ? ST_EMIT : ST_RD;
        end
      end

      ST_EMIT: begin
        if (oreg_free) begin
          ovld_nxt  = 1'b1;
          olast_nxt = last_r;
          if (cur_v_r) begin
            odata_nxt = {(num_r ? val_r : {VAL_W{1'b0}}), len_ext[LEN_W-1:0],
                         start_ext[START_W-1:0], idx_ext[IDX_W-1:0]};
            ouser_nxt = {1'b0, num_r};
          end else begin
            odata_nxt = '0;
            ouser_nxt = '0;
            ouser_nxt[TUSER_EMPTY] = 1'b1;
          end
          cur_v_nxt = 1'b0;
          if (last_r) begin
            cnt_nxt = '0;
            st_nxt  = ST_IDLE;
          end else begin
            st_nxt = ST_EV;
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      pos_r    <= '0;
      fld_r    <= '0;
      in_fld_r <= 1'b0;
      cur_v_r  <= 1'b0;
      last_r   <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      fld_r    <= fld_nxt;
      in_fld_r <= in_fld_nxt;
      cur_v_r  <= cur_v_nxt;
      last_r   <= last_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  // Field and output payload registers
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    num_r   <= num_nxt;
    val_r   <= val_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

FILE: hdl/lef_chk.sv
`default_nettype none
`include "line_edit_and_field_tokenizer_defines.svh"
module lef_chk
  import lef_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser,
  input wire logic                   out_tlast
);

  // Stalled result beat stays up
  `LEF_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out beat dropped while stalled")

  // Stalled result payload holds
  `LEF_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "out payload changed while stalled")

  // An empty line beat is the last one, with zero data and no numeric flag
  `LEF_ASSERT(a_empty_beat, clk, rst_n, out_tvalid && out_tuser[TUSER_EMPTY] |-> out_tlast && out_tdata == '0 && !out_tuser[TUSER_NUM], "empty line beat malformed")

  // No new character while a line is still being emitted
  `LEF_ASSERT(a_busy_mid_line, clk, rst_n, out_tvalid && !out_tlast |-> !in_tready, "input taken mid line")

  // Reset leaves no result pending
  `LEF_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_tvalid, "out valid after reset")

endmodule

bind line_edit_and_field_tokenizer lef_chk u_lef_chk (.*);
`default_nettype wire

FILE: sim/line_tokenizer_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the line tokenizer, predicts the field beats of
// every finished line and compares them in order with what comes out.
module line_tokenizer_checker
  import lef_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,    // [7:0] rx_char
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] field_index, [8:3] field_start, [15:9] field_length,
  // [47:16] field_value
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,   // [0] field_numeric, [1] line_empty
  input  logic                   out_tlast,   // last_field
  output int                     mismatches,
  output int                     fields_pending,
  output int                     lines_done,
  output int                     beats_checked
);

  localparam int STORE_CHARS = 64;
  localparam int FIELD_CAP   = 8;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               numeric;
    logic [VAL_W-1:0]   value;
    logic               empty;
    logic               last;
  } field_beat_t;

  logic [7:0]  line_chars [STORE_CHARS];
  int unsigned line_len;
  field_beat_t fields_due [$];
  field_beat_t want;
  logic [7:0]  rx;

  initial begin
    mismatches     = 0;
    fields_pending = 0;
    lines_done     = 0;
    beats_checked  = 0;
    line_len       = 0;
  end

  // digits are numeric, the rest of the printable set except space is alpha
  function automatic cls_t char_kind(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return CLS_NUM;
    if (c > CH_SPACE && c <= CH_TILDE) return CLS_ALPHA;
    return CLS_DELIM;
  endfunction

  task automatic report_fault(input string msg);
    $display("%0t checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_fault($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  // Split the stored line into fields and queue one beat per field
  task automatic close_line();
    field_beat_t found [FIELD_CAP];
    field_beat_t beat;
    int unsigned pos;
    int          n;
    int          k;
    pos = 0;
    n   = 0;
    while (pos < line_len && n < FIELD_CAP) begin
      if (char_kind(line_chars[pos]) == CLS_DELIM) begin
        pos++;
      end else begin
        beat         = '0;
        beat.index   = n[IDX_W-1:0];
        beat.start   = pos[START_W-1:0];
        beat.numeric = (char_kind(line_chars[pos]) == CLS_NUM);
        // a numeric field keeps accumulating through alpha chars too
        while (pos < line_len && char_kind(line_chars[pos]) != CLS_DELIM) begin
          beat.value  = beat.value * 32'd10 + {24'd0, line_chars[pos]} - 32'd48;
          beat.length = beat.length + 1'b1;
          pos++;
        end
        if (!beat.numeric) beat.value = '0;
        found[n] = beat;
        n++;
      end
    end
    if (n == 0) begin
      beat       = '0;
      beat.empty = 1'b1;
      beat.last  = 1'b1;
      fields_due.push_back(beat);
    end else begin
      found[n-1].last = 1'b1;
      for (k = 0; k < n; k++) fields_due.push_back(found[k]);
    end
    line_len = 0;
    lines_done++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_len = 0;
      fields_due.delete();
    end else begin
      // input beat: edit the line
      if (in_tvalid && in_tready) begin
        rx = in_tdata;
        if (rx >= CH_SPACE && rx <= CH_TILDE) begin
          if (line_len < STORE_CHARS) begin
            line_chars[line_len] = rx;
            line_len++;
          end
          if (line_len >= STORE_CHARS) close_line();
        end else if (rx == CH_BS || rx == CH_DEL) begin
          if (line_len > 0) line_len--;
        end else if (rx == CH_CR) begin
          close_line();
        end
      end
      // result beat: compare with the oldest expected field
      if (out_tvalid && out_tready) begin
        beats_checked++;
        if (fields_due.size() == 0) begin
          report_fault($sformatf("field beat with none expected, index %0d",
                                 out_tdata[IDX_W-1:0]));
        end else begin
          want = fields_due.pop_front();
          check_field("field_index", 32'(out_tdata[IDX_W-1:0]), 32'(want.index));
          check_field("field_start", 32'(out_tdata[IDX_W +: START_W]),
                      32'(want.start));
          check_field("field_length", 32'(out_tdata[IDX_W+START_W +: LEN_W]),
                      32'(want.length));
          check_field("field_numeric", 32'(out_tuser[TUSER_NUM]), 32'(want.numeric));
          check_field("field_value", out_tdata[IDX_W+START_W+LEN_W +: VAL_W],
                      want.value);
          check_field("line_empty", 32'(out_tuser[TUSER_EMPTY]), 32'(want.empty));
          check_field("last_field", 32'(out_tlast), 32'(want.last));
        end
      end
    end
    fields_pending <= fields_due.size();
  end

endmodule

FILE: sim/tb_line_edit_and_field_tokenizer.sv
`timescale 1ns / 1ps
module tb_line_edit_and_field_tokenizer;
  import lef_pkg::*;

  localparam int LINE_CHARS   = 64;
  localparam int FIELD_LIMIT  = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = 300;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int OPENING_LEN  = 22;

  // empty line, erase on empty, ignored codes, class boundaries, edit
  localparam logic [7:0] OPENING [OPENING_LEN] = '{
    CH_BS, CH_DEL, CH_CR, 8'd0, 8'd255, 8'd9, 8'd128, 8'd31,
    CH_SPACE, CH_BANG, CH_SLASH, CH_SPACE, CH_COLON, CH_TILDE, CH_SPACE,
    CH_NINE, 8'h61, CH_ZERO, CH_BS, CH_ZERO, 8'h35, CH_CR
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [7:0]             in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asks     = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int stim_len      = 0;
  int items_sent    = 0;
  int mismatches;
  int fields_pending;
  int lines_done;
  int beats_checked;

  always #5 clk = ~clk;

  line_edit_and_field_tokenizer #(
    .LINE_CHARS  (LINE_CHARS),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  line_tokenizer_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .fields_pending (fields_pending),
    .lines_done     (lines_done),
    .beats_checked  (beats_checked)
  );

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_done != hold_asks) begin
      hold_done  <= hold_asks;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d field beats still expected", fields_pending);
    $display("tb_line_edit_and_field_tokenizer: errors");
    $finish;
  end

  // One input beat, after a random gap; tracks line length for shaping
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= c;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (c >= CH_SPACE && c <= CH_TILDE) begin
      stim_len++;
      if (stim_len >= LINE_CHARS) stim_len = 0;
      items_sent++;
    end else if (c == CH_BS || c == CH_DEL) begin
      if (stim_len > 0) begin
        stim_len--;
        items_sent++;
      end
    end else if (c == CH_CR) begin
      stim_len = 0;
      items_sent++;
    end
  endtask

  // control or high code that the block drops
  task automatic send_noise();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while ((c >= CH_SPACE && c <= CH_DEL) || c == CH_BS || c == CH_CR);
    send_char(c);
  endtask

  task automatic send_erase();
    send_char($urandom_range(1) ? CH_BS : CH_DEL);
  endtask

  task automatic send_token(input bit numeric, input int n);
    logic [7:0] c;
    int k;
    for (k = 0; k < n && stim_len < LINE_CHARS - 2; k++) begin
      if (k == 0 && numeric) begin
        c = CH_ZERO + 8'($urandom_range(9));
      end else if (k == 0) begin
        do c = 8'($urandom_range(CH_TILDE, CH_BANG));
        while (c >= CH_ZERO && c <= CH_NINE);
      end else if (numeric && $urandom_range(9) < 8) begin
        c = CH_ZERO + 8'($urandom_range(9));
      end else begin
        c = 8'($urandom_range(CH_TILDE, CH_BANG));
      end
      if ($urandom_range(99) < 4) send_noise();
      if (k > 0 && $urandom_range(99) < 5) send_erase();
      send_char(c);
    end
  endtask

  // Printable chars with a few erases until the store fills and ends the line
  task automatic send_full_line();
    bit done;
    done = 1'b0;
    while (!done) begin
      if (stim_len > 1 && $urandom_range(99) < 5) send_erase();
      else if ($urandom_range(99) < 20) send_char(CH_SPACE);
      else send_char(8'($urandom_range(CH_TILDE, CH_BANG)));
      if (stim_len == 0) done = 1'b1;
    end
  endtask

  task automatic send_line();
    int kind;
    int n_fields;
    int k;
    kind = $urandom_range(99);
    if (kind < 6) begin
      send_full_line();
    end else if (kind < 10) begin
      // broken line: only noise and erases
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(1)) send_noise();
        else send_erase();
      end
      send_char(CH_CR);
    end else begin
      if (kind < 25) n_fields = $urandom_range(14, FIELD_LIMIT + 1);
      else if (kind < 40) n_fields = $urandom_range(3, 1);
      else n_fields = $urandom_range(6, 0);
      repeat ($urandom_range(2, 0)) send_char(CH_SPACE);
      for (k = 0; k < n_fields; k++) begin
        if (k > 0 && stim_len < LINE_CHARS - 2) begin
          repeat ($urandom_range(3) == 0 ? 2 : 1) send_char(CH_SPACE);
        end
        if (kind < 25) send_token(1'($urandom_range(1)), $urandom_range(3, 1));
        else if (kind < 40) send_token(1'b1, $urandom_range(20, 8));
        else send_token(1'($urandom_range(1)), $urandom_range(8, 1));
      end
      if ($urandom_range(99) < 10) repeat ($urandom_range(5, 1)) send_erase();
      send_char(CH_CR);
    end
  endtask

  initial begin
    int phase;
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < OPENING_LEN; i++) send_char(OPENING[i]);

    // free flow, sender idle, receiver stall, light mix of both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 87; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 87; end
        default: begin send_idle_pct = 9; stall_pct <= 9; end
      endcase
      // long output hold-off while lines keep coming in
      if (phase == 0) hold_asks <= hold_asks + 1;
      while (items_sent < PHASE_ITEMS * (phase + 1)) send_line();
    end
    in_tvalid <= 1'b0;

    while (fields_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats, %0d lines, %0d field beats over four idle mixes",
             items_sent, lines_done, beats_checked);
    $display("with one long output hold-off; %0d mismatches, %0d beats left undelivered",
             mismatches, fields_pending);
    if (mismatches == 0 && fields_pending == 0) begin
      $display("tb_line_edit_and_field_tokenizer: clean");
    end else begin
      $display("tb_line_edit_and_field_tokenizer: errors");
    end
    $finish;
  end

endmodule
